// File: hw/rtl/edge_list_selection_sorter_assert.svh
// Assertion macros used by the checker file.
`ifndef EDGE_LIST_SELECTION_SORTER_ASSERT_SVH
`define EDGE_LIST_SELECTION_SORTER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define ELSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define ELSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/elss_pkg.sv
`timescale 1ns / 1ps

package elss_pkg;

    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int PORT_V_W = 8;
    localparam int WEIGHT_W = 32;
    localparam int POS_W    = 8;
    localparam int LEN_W    = 9;

    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SORT   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd3;

    localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;

    typedef struct packed {
        logic                do_append;
        logic                do_remove;
        logic                start_sort;
        logic                rd_pos;
        logic                rd_first;
        logic                rd_scan;
        logic                load_min;
        logic                cmp_min;
        logic                wr_first;
        logic                wr_min;
        logic                next_pass;
        logic                out_load;
        logic [STATUS_W-1:0] res_status;
        logic                res_data;
    } elss_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic lt_two;
        logic scan_more;
        logic pass_more;
        logic min_moved;
        logic out_free;
    } elss_stat_t;

endpackage

// File: hw/rtl/elss_if.sv
`timescale 1ns / 1ps

interface elss_req_if;
    import elss_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [REQ_W-1:0]           req_type;
    logic [PORT_V_W-1:0]        edge_from;
    logic [PORT_V_W-1:0]        edge_to;
    logic signed [WEIGHT_W-1:0] edge_weight;
    logic [POS_W-1:0]           position;

    modport source (
        output valid, req_type, edge_from, edge_to, edge_weight, position,
        input  ready
    );

    modport sink (
        input  valid, req_type, edge_from, edge_to, edge_weight, position,
        output ready
    );
endinterface

interface elss_rsp_if;
    import elss_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic [PORT_V_W-1:0]        out_from;
    logic [PORT_V_W-1:0]        out_to;
    logic signed [WEIGHT_W-1:0] out_weight;
    logic [LEN_W-1:0]           list_length;

    modport source (
        output valid, status, out_from, out_to, out_weight, list_length,
        input  ready
    );

    modport sink (
        input  valid, status, out_from, out_to, out_weight, list_length,
        output ready
    );
endinterface

// File: hw/rtl/elss_ctrl.sv
`timescale 1ns / 1ps

module elss_ctrl
    import elss_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic [REQ_W-1:0] req_type,
    output logic             req_ready,
    input  elss_stat_t       stat,
    output elss_cmd_t        cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RESP  = 3'd1;
    localparam logic [2:0] S_FIRST = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_SWAP1 = 3'd5;
    localparam logic [2:0] S_SWAP2 = 3'd6;
    localparam logic [2:0] S_NEXT  = 3'd7;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [STATUS_W-1:0] res_status_reg;
    logic [STATUS_W-1:0] res_status_next;
    logic                res_data_reg;
    logic                res_data_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        cmd             = '0;
        cmd.res_status  = res_status_reg;
        cmd.res_data    = res_data_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_status_next = STS_OK;
                    res_data_next   = 1'b0;
                    state_next      = S_RESP;
                    unique case (req_type)
                        REQ_APPEND:
                        begin
                            if (stat.full)
                                res_status_next = STS_FULL;
                            else
                                cmd.do_append = 1'b1;
                        end
                        REQ_SORT:
                        begin
                            if (!stat.lt_two)
                            begin
                                cmd.start_sort = 1'b1;
                                state_next     = S_FIRST;
                            end
                        end
                        REQ_READ:
                        begin
                            if (stat.empty)
                                res_status_next = STS_EMPTY;
                            else
                            begin
                                cmd.rd_pos    = 1'b1;
                                res_data_next = 1'b1;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (stat.empty)
                                res_status_next = STS_EMPTY;
                            else
                                cmd.do_remove = 1'b1;
                        end
                    endcase
                end
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_FIRST:
            begin
                cmd.rd_first = 1'b1;
                state_next   = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load_min = 1'b1;
                cmd.rd_scan  = 1'b1;
                state_next   = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.cmp_min = 1'b1;
                if (stat.scan_more)
                    cmd.rd_scan = 1'b1;
                else
                    state_next = S_SWAP1;
            end
            S_SWAP1:
            begin
                if (stat.min_moved)
                begin
                    cmd.wr_first = 1'b1;
                    state_next   = S_SWAP2;
                end
                else
                    state_next = S_NEXT;
            end
            S_SWAP2:
            begin
                cmd.wr_min = 1'b1;
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                cmd.next_pass = 1'b1;
                if (stat.pass_more)
                    state_next = S_FIRST;
                else
                    state_next = S_RESP;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            res_status_reg <= STS_OK;
            res_data_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
            res_data_reg   <= res_data_next;
        end
    end

endmodule

// File: hw/rtl/elss_datapath.sv
`timescale 1ns / 1ps

module elss_datapath
    import elss_pkg::*;
#(
    parameter int MAX_EDGES   = 256,
    parameter int VERTEX_BITS = 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [PORT_V_W-1:0]        edge_from,
    input  logic [PORT_V_W-1:0]        edge_to,
    input  logic signed [WEIGHT_W-1:0] edge_weight,
    input  logic [POS_W-1:0]           position,
    input  elss_cmd_t                  cmd,
    output elss_stat_t                 stat,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [STATUS_W-1:0]        out_status,
    output logic [PORT_V_W-1:0]        out_from,
    output logic [PORT_V_W-1:0]        out_to,
    output logic signed [WEIGHT_W-1:0] out_weight,
    output logic [LEN_W-1:0]           out_len
);

    localparam int SLOT_W  = $clog2(MAX_EDGES);
    localparam int CNT_W   = $clog2(MAX_EDGES + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int ENTRY_W = 2 * VERTEX_BITS + WEIGHT_W;
    localparam int TO_LO   = WEIGHT_W;
    localparam int FROM_LO = WEIGHT_W + VERTEX_BITS;

    logic [ENTRY_W-1:0] mem [MAX_EDGES];

    logic [SLOT_W-1:0]  head_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               out_valid_reg;

    logic [ENTRY_W-1:0] rd_data_reg;
    logic [SLOT_W-1:0]  rd_slot_reg;
    logic [CNT_W-1:0]   i_reg;
    logic [CNT_W-1:0]   j_reg;
    logic [SLOT_W-1:0]  si_reg;
    logic [ENTRY_W-1:0] min_entry_reg;
    logic [SLOT_W-1:0]  min_slot_reg;
    logic [ENTRY_W-1:0] first_entry_reg;

    logic [STATUS_W-1:0]        out_status_reg;
    logic [PORT_V_W-1:0]        out_from_reg;
    logic [PORT_V_W-1:0]        out_to_reg;
    logic signed [WEIGHT_W-1:0] out_weight_reg;
    logic [LEN_W-1:0]           out_len_reg;

    logic [CNT_W-1:0]   pos_clamped;
    logic [CNT_W-1:0]   rd_off;
    logic [SLOT_W-1:0]  rd_slot;
    logic               rd_en;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_slot;
    logic [ENTRY_W-1:0] wr_data;
    logic               take_min;

    function automatic logic [SLOT_W-1:0] slot_of(
        input logic [SLOT_W-1:0] head,
        input logic [CNT_W-1:0]  off
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(off);
        if (sum >= SUM_W'(MAX_EDGES))
            sum = sum - SUM_W'(MAX_EDGES);
        return SLOT_W'(sum);
    endfunction

    // Ascending weight, then ascending source vertex; equal keys never sort before each other.
    function automatic logic sorts_before(
        input logic [ENTRY_W-1:0] a,
        input logic [ENTRY_W-1:0] b
    );
        logic signed [WEIGHT_W-1:0] wa;
        logic signed [WEIGHT_W-1:0] wb;
        logic [VERTEX_BITS-1:0]     fa;
        logic [VERTEX_BITS-1:0]     fb;
        wa = $signed(a[WEIGHT_W-1:0]);
        wb = $signed(b[WEIGHT_W-1:0]);
        fa = a[FROM_LO +: VERTEX_BITS];
        fb = b[FROM_LO +: VERTEX_BITS];
        if (wa != wb)
            return wa < wb;
        return fa < fb;
    endfunction

    always_comb
    begin
        if (CMP_W'(position) >= CMP_W'(count_reg))
            pos_clamped = count_reg - CNT_W'(1);
        else
            pos_clamped = CNT_W'(position);

        priority if (cmd.rd_pos)
            rd_off = pos_clamped;
        else if (cmd.rd_first)
            rd_off = i_reg;
        else
            rd_off = j_reg;
        rd_slot = slot_of(head_reg, rd_off);
        rd_en   = cmd.rd_pos | cmd.rd_first | cmd.rd_scan;

        wr_en = cmd.do_append | cmd.wr_first | cmd.wr_min;
        priority if (cmd.do_append)
        begin
            wr_slot = slot_of(head_reg, count_reg);
            wr_data = {VERTEX_BITS'(edge_from), VERTEX_BITS'(edge_to), edge_weight};
        end
        else if (cmd.wr_first)
        begin
            wr_slot = si_reg;
            wr_data = min_entry_reg;
        end
        else
        begin
            wr_slot = min_slot_reg;
            wr_data = first_entry_reg;
        end

        take_min = cmd.cmp_min && sorts_before(rd_data_reg, min_entry_reg);
    end

    always_comb
    begin
        stat.empty     = (count_reg == '0);
        stat.full      = (count_reg == CNT_W'(MAX_EDGES));
        stat.lt_two    = (count_reg < CNT_W'(2));
        stat.scan_more = (j_reg < count_reg);
        stat.pass_more = ((SUM_W'(i_reg) + SUM_W'(2)) < SUM_W'(count_reg));
        stat.min_moved = (min_slot_reg != si_reg);
        stat.out_free  = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_slot] <= wr_data;
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_slot];
            rd_slot_reg <= rd_slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.do_append)
            count_reg <= count_reg + CNT_W'(1);
        else if (cmd.do_remove)
        begin
            head_reg  <= slot_of(head_reg, CNT_W'(1));
            count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_sort)
            i_reg <= '0;
        else if (cmd.next_pass)
            i_reg <= i_reg + CNT_W'(1);

        if (cmd.rd_first)
        begin
            si_reg <= rd_slot;
            j_reg  <= i_reg + CNT_W'(1);
        end
        else if (cmd.rd_scan)
            j_reg <= j_reg + CNT_W'(1);

        if (cmd.load_min)
        begin
            min_entry_reg   <= rd_data_reg;
            first_entry_reg <= rd_data_reg;
            min_slot_reg    <= rd_slot_reg;
        end
        else if (take_min)
        begin
            min_entry_reg <= rd_data_reg;
            min_slot_reg  <= rd_slot_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.res_status;
            out_len_reg    <= LEN_W'(count_reg);
            if (cmd.res_data)
            begin
                out_from_reg   <= PORT_V_W'(rd_data_reg[FROM_LO +: VERTEX_BITS]);
                out_to_reg     <= PORT_V_W'(rd_data_reg[TO_LO +: VERTEX_BITS]);
                out_weight_reg <= $signed(rd_data_reg[WEIGHT_W-1:0]);
            end
            else
            begin
                out_from_reg   <= '0;
                out_to_reg     <= '0;
                out_weight_reg <= '0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_from   = out_from_reg;
    assign out_to     = out_to_reg;
    assign out_weight = out_weight_reg;
    assign out_len    = out_len_reg;

endmodule

// File: hw/rtl/edge_list_selection_sorter.sv
`timescale 1ns / 1ps
// Append, read, remove and a sort of fewer than two entries: the controller goes to a
// response state, loads the result register once it is free and then takes the next item
// back in idle. One item is in work at a time.
// Sort of N entries: N-1 passes, each scanning the remaining entries over the single read port
// of the edge memory and swapping at most once, so at most N-1 swaps.
// Reset clears head, length, the controller and the result valid; the memory is not cleared.
module edge_list_selection_sorter
    import elss_pkg::*;
#(
    parameter int MAX_EDGES   = 256,
    parameter int VERTEX_BITS = 8
)
(
    input logic         clk,
    input logic         rst_n,
    elss_req_if.sink    req,
    elss_rsp_if.source  rsp
);

    elss_cmd_t  cmd;
    elss_stat_t stat;

    elss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    elss_datapath #(
        .MAX_EDGES   (MAX_EDGES),
        .VERTEX_BITS (VERTEX_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .edge_from   (req.edge_from),
        .edge_to     (req.edge_to),
        .edge_weight (req.edge_weight),
        .position    (req.position),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .out_status  (rsp.status),
        .out_from    (rsp.out_from),
        .out_to      (rsp.out_to),
        .out_weight  (rsp.out_weight),
        .out_len     (rsp.list_length)
    );

endmodule

// File: hw/rtl/elss_checker.sv
`timescale 1ns / 1ps
`include "edge_list_selection_sorter_assert.svh"

module elss_checker
    import elss_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic [STATUS_W-1:0]        status,
    input logic [PORT_V_W-1:0]        out_from,
    input logic [PORT_V_W-1:0]        out_to,
    input logic signed [WEIGHT_W-1:0] out_weight,
    input logic [LEN_W-1:0]           list_length
);

    `ELSS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(list_length), "result dropped or changed while stalled")
    `ELSS_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready, "second item accepted before the first one finished")
    `ELSS_ASSERT_NOW(a_empty_len, rsp_valid && status == STS_EMPTY, list_length == '0, "empty status with a nonzero length")
    `ELSS_ASSERT_NOW(a_no_data, rsp_valid && status != STS_OK, out_from == '0 && out_to == '0 && out_weight == '0, "data fields set on a refused request")

endmodule

bind edge_list_selection_sorter elss_checker u_elss_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .out_from    (rsp.out_from),
    .out_to      (rsp.out_to),
    .out_weight  (rsp.out_weight),
    .list_length (rsp.list_length)
);
